// ===== hw/rtl/ile_pkg.sv =====
// Shared types and constants of the indexed list engine.
package ile_pkg;

   localparam int CMD_W = 2;
   localparam int IDX_W = 7;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   localparam int FPOS_W = 7;

   localparam logic [FPOS_W-1:0] NO_POS = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET    = 2'd0,
      CMD_LOCATE = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_DELETE = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_POST
   } fsm_state_type;

   typedef struct packed {
      logic hit;
      logic [DATA_W-1:0] data;
      logic [FPOS_W-1:0] pos;
   } carrier_type;

   typedef struct packed {
      logic insert_en;
      logic delete_en;
      command_type cmd;
      logic [IDX_W-1:0] index;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/ile_req_if.sv =====
// Command channel of the indexed list engine.
interface ile_req_if import ile_pkg::*; ();
   logic valid;
   logic ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, index, value, input ready);
   modport sink (input valid, command, index, value, output ready);
endinterface

// ===== hw/rtl/ile_rsp_if.sv =====
// Result channel of the indexed list engine.
interface ile_rsp_if import ile_pkg::*; ();
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic signed [DATA_W-1:0] read_value;
   logic signed [FPOS_W-1:0] found_position;
   logic [IDX_W-1:0] count;

   modport source (output valid, status, read_value, found_position, count, input ready);
   modport sink (input valid, status, read_value, found_position, count, output ready);
endinterface

// ===== hw/rtl/indexed_list_engine_top.sv =====
// Get, locate, insert and delete run one command at a time; each command is one transfer.
// Get and delete inside the list and every locate pass through a scan state, in which the
// carrier walks the DEPTH cells one cell per cycle, before the result is registered; other
// commands go straight to the completion step. A command is taken only once the last one is done.
// The next command is taken while a result waits; it stalls only until that result is taken.
// Reset empties the list by clearing the count; cell contents past the count are unused.
module indexed_list_engine_top import ile_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   ile_req_if.sink req_ch,
   ile_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_ctrl_type cell_ctrl;
   logic [CNT_W-1:0] count;
   logic [DATA_W-1:0] entry_bus [DEPTH];
   carrier_type carrier_bus [DEPTH];
   carrier_type carrier_head;

   assign carrier_head = '0;

   ile_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .scan_result(carrier_bus[DEPTH-1]),
      .cell_ctrl(cell_ctrl),
      .count(count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;
      carrier_type carrier_in;

      if (i == 0) begin : g_first
         assign left_data = '0;
         assign carrier_in = carrier_head;
      end else begin : g_inner
         assign left_data = entry_bus[i-1];
         assign carrier_in = carrier_bus[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_body
         assign right_data = entry_bus[i+1];
      end

      ile_cell #(
         .CNT_W(CNT_W),
         .POS(i)
      ) u_cell (
         .clock(clock),
         .ctrl(cell_ctrl),
         .count(count),
         .left_data(left_data),
         .right_data(right_data),
         .carrier_in(carrier_in),
         .data(entry_bus[i]),
         .carrier_out(carrier_bus[i])
      );
   end

endmodule

// ===== hw/rtl/ile_cell.sv =====
// One list cell: holds one entry, shifts with its neighbors and forwards the scan carrier.
module ile_cell import ile_pkg::*; #(
   parameter int CNT_W = 7,
   parameter int POS = 0
) (
   input  logic clock,
   input  cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   input  carrier_type carrier_in,
   output logic [DATA_W-1:0] data,
   output carrier_type carrier_out
);

   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

   logic [DATA_W-1:0] entry_ff, entry_in;
   carrier_type carrier_ff, carrier_in_next;
   logic [CMP_W-1:0] idx_c, cnt_c;
   logic sel;

   assign idx_c = CMP_W'(ctrl.index);
   assign cnt_c = CMP_W'(count);

   always_comb begin
      if (ctrl.cmd == CMD_LOCATE) begin
         sel = (POS_C < cnt_c) && (entry_ff == ctrl.value);
      end else begin
         sel = (POS_C == idx_c);
      end
   end

   // The first selected cell along the chain claims the carrier.
   always_comb begin
      carrier_in_next = carrier_in;
      if (!carrier_in.hit && sel) begin
         carrier_in_next.hit = 1'b1;
         carrier_in_next.data = entry_ff;
         carrier_in_next.pos = FPOS_W'(POS);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (POS_C == idx_c) begin
            entry_in = ctrl.value;
         end else if (POS_C > idx_c) begin
            entry_in = left_data;
         end
      end else if (ctrl.delete_en) begin
         if (POS_C >= idx_c) begin
            entry_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carrier_ff <= carrier_in_next;
   end

   assign data = entry_ff;
   assign carrier_out = carrier_ff;

endmodule

// ===== hw/rtl/ile_ctrl.sv =====
// Command sequencer, entry count and result register of the indexed list engine.
module ile_ctrl import ile_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   ile_req_if.sink req_ch,
   ile_rsp_if.source rsp_ch,
   input  carrier_type scan_result,
   output cell_ctrl_type cell_ctrl,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SCAN_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DEPTH - 1);

   fsm_state_type state_ff, state_in;
   command_type cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [DATA_W-1:0] val_ff;
   status_type status_ff, status_in;
   logic [SCAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [DATA_W-1:0] rsp_read_ff;
   logic [FPOS_W-1:0] rsp_pos_ff;
   logic [IDX_W-1:0] rsp_count_ff;

   command_type req_cmd;
   logic [CMP_W-1:0] idx_c, cnt_c;
   logic accept, need_scan, out_free, post_fire, scan_last;
   status_type status_final;
   logic op_ok;

   assign req_cmd = command_type'(req_ch.command);
   assign idx_c = CMP_W'(req_ch.index);
   assign cnt_c = CMP_W'(cnt_ff);
   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign scan_last = (scan_cnt_ff == SCAN_LAST);

   always_comb begin
      case (req_cmd)
         CMD_GET, CMD_DELETE: status_in = (idx_c < cnt_c) ? ST_OK : ST_RANGE;
         CMD_INSERT: begin
            if (cnt_ff == FULL_CNT) begin
               status_in = ST_FULL;
            end else if (idx_c > cnt_c) begin
               status_in = ST_RANGE;
            end else begin
               status_in = ST_OK;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   assign need_scan = (status_in == ST_OK) && (req_cmd != CMD_INSERT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = need_scan ? FSM_SCAN : FSM_POST;
            end
         end
         FSM_SCAN: begin
            if (scan_last) begin
               state_in = FSM_POST;
            end
         end
         FSM_POST: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == FSM_IDLE);
      post_fire = (state_ff == FSM_POST) && out_free;
      scan_cnt_in = (state_ff == FSM_SCAN) ? scan_cnt_ff + SCAN_W'(1) : '0;
   end

   always_comb begin
      if (cmd_ff == CMD_LOCATE && status_ff == ST_OK && !scan_result.hit) begin
         status_final = ST_MISSING;
      end else begin
         status_final = status_ff;
      end
      op_ok = (status_final == ST_OK);
      if (op_ok && cmd_ff == CMD_INSERT) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (op_ok && cmd_ff == CMD_DELETE) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      if (post_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (post_fire) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_ch.index;
         val_ff <= req_ch.value;
         status_ff <= status_in;
      end
      if (post_fire) begin
         rsp_status_ff <= status_final;
         rsp_read_ff <= (op_ok && (cmd_ff == CMD_GET || cmd_ff == CMD_DELETE)) ?
                        scan_result.data : '0;
         rsp_pos_ff <= (op_ok && cmd_ff == CMD_LOCATE) ? scan_result.pos : NO_POS;
         rsp_count_ff <= IDX_W'(cnt_in);
      end
   end

   always_comb begin
      cell_ctrl.insert_en = post_fire && op_ok && (cmd_ff == CMD_INSERT);
      cell_ctrl.delete_en = post_fire && op_ok && (cmd_ff == CMD_DELETE);
      cell_ctrl.cmd = cmd_ff;
      cell_ctrl.index = idx_ff;
      cell_ctrl.value = val_ff;
   end

   assign count = cnt_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.read_value = rsp_read_ff;
   assign rsp_ch.found_position = rsp_pos_ff;
   assign rsp_ch.count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("Entry count exceeds the list depth.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != FSM_IDLE)
      else $error("Accepted command did not start.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.insert_en |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("Insert did not grow the count.");

   a_result_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == FSM_POST)
      else $error("Result appeared outside the completion step.");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the indexed list engine: directed table, then biased random traffic.
module tb import ile_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1025;

   typedef struct packed {
      status_type status;
      logic [DATA_W-1:0] read_value;
      logic [FPOS_W-1:0] found_position;
      logic [IDX_W-1:0] count;
   } list_result_type;

   typedef struct packed {
      command_type cmd;
      logic [IDX_W-1:0] index;
      logic [DATA_W-1:0] value;
      logic typed;
      list_result_type want;
   } command_row_type;

   typedef enum int {
      BIAS_FILL,
      BIAS_DRAIN,
      BIAS_MIXED
   } bias_type;

   logic clock;
   logic reset;

   ile_req_if req_ch ();
   ile_rsp_if rsp_ch ();

   indexed_list_engine_top #(.DEPTH(LIST_DEPTH)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int list_len;
   int peak_len;

   list_result_type pending_results [$];
   command_row_type directed_rows [$];

   int sent_items;
   int checked_results;
   int error_count;
   int burst_left;
   int cmd_seen [4];
   int status_seen [4];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   function automatic list_result_type apply_list_command(command_type cmd,
                                                          logic [IDX_W-1:0] index,
                                                          logic [DATA_W-1:0] value);
      list_result_type r;
      int pos;
      int k;
      logic hit;
      pos = int'(index);
      r.status = ST_OK;
      r.read_value = '0;
      r.found_position = NO_POS;
      hit = 1'b0;
      case (cmd)
         CMD_GET: begin
            if (pos >= list_len) r.status = ST_RANGE;
            else r.read_value = list_words[pos];
         end
         CMD_LOCATE: begin
            r.status = ST_MISSING;
            for (k = 0; k < list_len && !hit; k++) begin
               if (list_words[k] == value) begin
                  hit = 1'b1;
                  r.found_position = FPOS_W'(k);
                  r.status = ST_OK;
               end
            end
         end
         CMD_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (pos > list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = value;
               list_len++;
            end
         end
         default: begin
            if (pos >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.read_value = list_words[pos];
               for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
      endcase
      r.count = IDX_W'(list_len);
      return r;
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t ns: %s", $time, what);
   endtask

   task automatic add_row(input command_type cmd, input int index,
                          input logic [DATA_W-1:0] value,
                          input logic typed, input status_type st,
                          input logic [DATA_W-1:0] rd, input logic [FPOS_W-1:0] pos,
                          input int cnt);
      command_row_type row;
      row.cmd = cmd;
      row.index = IDX_W'(index);
      row.value = value;
      row.typed = typed;
      row.want.status = st;
      row.want.read_value = rd;
      row.want.found_position = pos;
      row.want.count = IDX_W'(cnt);
      directed_rows.push_back(row);
   endtask

   task automatic send_command(input command_type cmd, input logic [IDX_W-1:0] index,
                               input logic [DATA_W-1:0] value, input logic typed,
                               input list_result_type want);
      list_result_type r;
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.index <= index;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      r = apply_list_command(cmd, index, value);
      pending_results.push_back(typed ? want : r);
      sent_items++;
      cmd_seen[cmd]++;
      status_seen[r.status]++;
      if (list_len > peak_len) peak_len = list_len;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);
   endtask

   task automatic run_random_phase(input bias_type bias, input int n_items);
      command_type cmd;
      logic [IDX_W-1:0] index;
      logic [DATA_W-1:0] value;
      int roll;
      int top;
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         case (bias)
            BIAS_FILL:
               cmd = roll < 60 ? CMD_INSERT : roll < 75 ? CMD_GET :
                     roll < 90 ? CMD_LOCATE : CMD_DELETE;
            BIAS_DRAIN:
               cmd = roll < 60 ? CMD_DELETE : roll < 75 ? CMD_GET :
                     roll < 90 ? CMD_LOCATE : CMD_INSERT;
            default:
               cmd = command_type'(roll % 4);
         endcase
         top = (cmd == CMD_INSERT) ? list_len : list_len - 1;
         if (top >= 0 && $urandom_range(0, 9) < 8) index = IDX_W'($urandom_range(0, top));
         else index = IDX_W'($urandom_range(0, 127));
         if (cmd == CMD_LOCATE && list_len > 0 && $urandom_range(0, 9) < 6) begin
            value = list_words[$urandom_range(0, list_len - 1)];
         end else begin
            case ($urandom_range(0, 9))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = '1;
               3, 4, 5: value = DATA_W'($urandom_range(0, 7)) - 32'd4;
               default: value = $urandom;
            endcase
         end
         send_command(cmd, index, value, 1'b0, '0);
      end
   endtask

   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         n = $urandom_range(0, 3);
         repeat ($urandom_range(16, 80)) begin
            @(posedge clock);
            case (n)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ~rsp_ch.ready;
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = status_type'(rsp_ch.status);
         got.read_value = rsp_ch.read_value;
         got.found_position = rsp_ch.found_position;
         got.count = rsp_ch.count;
         checked_results++;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected transfer: status %0d read %h pos %h count %0d",
                                   got.status, got.read_value, got.found_position, got.count));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_position !== want.found_position || got.count !== want.count) begin
               note_failure($sformatf({"result %0d: got status %0d read %h pos %h count %0d, ",
                                       "expected status %0d read %h pos %h count %0d"},
                                      checked_results, got.status, got.read_value,
                                      got.found_position, got.count, want.status,
                                      want.read_value, want.found_position, want.count));
            end
         end
      end
   end

   initial begin
      int phase_len;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_GET;
      req_ch.index <= '0;
      req_ch.value <= '0;
      list_len = 0;
      peak_len = 0;
      sent_items = 0;
      checked_results = 0;
      error_count = 0;
      burst_left = 1;
      cmd_seen = '{default: 0};
      status_seen = '{default: 0};
      for (int k = 0; k < LIST_DEPTH; k++) list_words[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(CMD_GET,    0,   32'h0,         1, ST_RANGE,   32'h0,         NO_POS, 0);
      add_row(CMD_DELETE, 0,   32'h0,         1, ST_RANGE,   32'h0,         NO_POS, 0);
      add_row(CMD_LOCATE, 0,   32'h0,         1, ST_MISSING, 32'h0,         NO_POS, 0);
      add_row(CMD_INSERT, 1,   32'h5,         1, ST_RANGE,   32'h0,         NO_POS, 0);
      add_row(CMD_INSERT, 0,   32'h8000_0000, 1, ST_OK,      32'h0,         NO_POS, 1);
      add_row(CMD_INSERT, 1,   32'h7FFF_FFFF, 1, ST_OK,      32'h0,         NO_POS, 2);
      add_row(CMD_INSERT, 1,   32'hFFFF_FFFF, 1, ST_OK,      32'h0,         NO_POS, 3);
      add_row(CMD_GET,    0,   32'h0,         1, ST_OK,      32'h8000_0000, NO_POS, 3);
      add_row(CMD_GET,    2,   32'h0,         1, ST_OK,      32'h7FFF_FFFF, NO_POS, 3);
      add_row(CMD_GET,    3,   32'h0,         1, ST_RANGE,   32'h0,         NO_POS, 3);
      add_row(CMD_GET,    127, 32'h0,         1, ST_RANGE,   32'h0,         NO_POS, 3);
      add_row(CMD_LOCATE, 0,   32'hFFFF_FFFF, 1, ST_OK,      32'h0,         7'd1,   3);
      add_row(CMD_LOCATE, 0,   32'h0,         1, ST_MISSING, 32'h0,         NO_POS, 3);
      add_row(CMD_INSERT, 0,   32'h0,         1, ST_OK,      32'h0,         NO_POS, 4);
      add_row(CMD_LOCATE, 0,   32'h0,         1, ST_OK,      32'h0,         7'd0,   4);
      add_row(CMD_INSERT, 4,   32'h7FFF_FFFF, 1, ST_OK,      32'h0,         NO_POS, 5);
      add_row(CMD_LOCATE, 0,   32'h7FFF_FFFF, 1, ST_OK,      32'h0,         7'd3,   5);
      add_row(CMD_INSERT, 127, 32'h1,         1, ST_RANGE,   32'h0,         NO_POS, 5);
      add_row(CMD_INSERT, 6,   32'h1,         1, ST_RANGE,   32'h0,         NO_POS, 5);
      add_row(CMD_DELETE, 5,   32'h0,         1, ST_RANGE,   32'h0,         NO_POS, 5);
      add_row(CMD_DELETE, 4,   32'h0,         1, ST_OK,      32'h7FFF_FFFF, NO_POS, 4);
      add_row(CMD_DELETE, 0,   32'h0,         1, ST_OK,      32'h0,         NO_POS, 3);
      add_row(CMD_DELETE, 1,   32'h0,         0, ST_OK,      32'h0,         NO_POS, 0);
      add_row(CMD_LOCATE, 0,   32'h7FFF_FFFF, 0, ST_OK,      32'h0,         NO_POS, 0);
      add_row(CMD_GET,    1,   32'h0,         0, ST_OK,      32'h0,         NO_POS, 0);

      foreach (directed_rows[k]) begin
         send_command(directed_rows[k].cmd, directed_rows[k].index, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].want);
      end
      settle_pipeline();

      run_random_phase(BIAS_FILL, 160);
      run_random_phase(BIAS_DRAIN, 170);
      settle_pipeline();
      while (sent_items < directed_rows.size() + RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 150);
         if (phase_len > directed_rows.size() + RANDOM_ITEMS - sent_items) begin
            phase_len = directed_rows.size() + RANDOM_ITEMS - sent_items;
         end
         run_random_phase(bias_type'($urandom_range(0, 2)), phase_len);
         if ($urandom_range(0, 3) == 0) settle_pipeline();
      end
      settle_pipeline();

      $display("Sent %0d commands (get %0d, locate %0d, insert %0d, delete %0d), %s",
               sent_items, cmd_seen[CMD_GET], cmd_seen[CMD_LOCATE], cmd_seen[CMD_INSERT],
               cmd_seen[CMD_DELETE], $sformatf("checked %0d results.", checked_results));
      $display("Peak list length %0d of %0d; %0d range errors, %0d full refusals, %s",
               peak_len, LIST_DEPTH, status_seen[ST_RANGE], status_seen[ST_FULL],
               $sformatf("%0d locate misses.", status_seen[ST_MISSING]));
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total.", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
